// ===== rtl/cdt_pkg.sv =====
package cdt_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HANDLE_BITS = 8;
  localparam int PORT_W      = 16;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int HFIELD_W    = 8;

  // stream word layout
  localparam int IN_W      = 48;
  localparam int OUT_W     = 16;
  localparam int IN_CMD_LO = 0;
  localparam int IN_LP_LO  = IN_CMD_LO + CMD_W;
  localparam int IN_RP_LO  = IN_LP_LO + PORT_W;
  localparam int IN_H_LO   = IN_RP_LO + PORT_W;
  localparam int IN_USED_W = IN_H_LO + HFIELD_W;
  localparam int OUT_USED_W = HFIELD_W + STATUS_W;

  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_HANDLE = 2'd3;

  localparam logic [PORT_W-1:0] ANY_REMOTE = '0;

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [PORT_W-1:0]      port_t;

  typedef struct packed {
    handle_t handle;
    port_t   remote_port;
    port_t   local_port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // per-slot compare flags
  typedef struct packed {
    logic exact;
    logic wild;
    logic free;
    logic hold;
  } cmp_t;

endpackage

// ===== rtl/connection_demux_table_unit.sv =====
// throughput: one item at a time; lookup, register and unregister scan the slots through one
// compare unit fed from the single read port of the slot memory, one slot per cycle, while a
// register or unregister with a zero handle, or an unused command, skips the scan
// reset: slot valid bits clear at once, so the table is empty right after reset
module connection_demux_table_unit import cdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [IN_W-1:0]  s_tdata_i,   // cmd, local_port, remote_port, handle
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o    // found_handle, status
);

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_DONE = 3'b100
  } state_e;

  state_e                state_q;
  logic [CMD_W-1:0]      cmd_q;
  port_t                 lp_q;
  port_t                 rp_q;
  handle_t               h_q;
  logic [IDX_W:0]        idx_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  handle_t               wild_q;
  handle_t               res_found_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [SLOTS-1:0]      vld_q;
  logic                  m_tvalid_q;
  logic [OUT_W-1:0]      m_data_q;

  logic                  in_xfer;
  logic                  issue_vld;
  logic [CMD_W-1:0]      in_cmd;
  handle_t               in_h;
  entry_t                rd_entry;
  entry_t                wr_entry;
  logic                  ram_we;
  cmp_t                  cmp;

  assign s_tready_o = (state_q == FSM_IDLE);
  assign in_xfer    = s_tvalid_i && s_tready_o;
  assign in_cmd     = s_tdata_i[IN_CMD_LO +: CMD_W];
  assign in_h       = s_tdata_i[IN_H_LO +: HANDLE_BITS];
  assign issue_vld  = (idx_q < (IDX_W + 1)'(SLOTS));

  assign wr_entry = '{handle: h_q, remote_port: rp_q, local_port: lp_q};
  assign ram_we   = (state_q == FSM_SCAN) && cmp_vld_q && (cmd_q == CMD_REGISTER) && cmp.free;

  cdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmp_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  cdt_slot_cmp u_cmp (
    .entry_i       (rd_entry),
    .valid_i       (vld_q[cmp_idx_q]),
    .local_port_i  (lp_q),
    .remote_port_i (rp_q),
    .handle_i      (h_q),
    .cmp_o         (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      cmd_q        <= CMD_LOOKUP;
      lp_q         <= '0;
      rp_q         <= '0;
      h_q          <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      wild_q       <= '0;
      res_found_q  <= '0;
      res_status_q <= ST_OK;
      vld_q        <= '0;
      m_tvalid_q   <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // in the done state the result register is refilled below instead
      if (m_tvalid_q && m_tready_i && (state_q != FSM_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        FSM_IDLE: begin
          if (in_xfer) begin
            cmd_q        <= in_cmd;
            lp_q         <= s_tdata_i[IN_LP_LO +: PORT_W];
            rp_q         <= s_tdata_i[IN_RP_LO +: PORT_W];
            h_q          <= in_h;
            idx_q        <= '0;
            cmp_vld_q    <= 1'b0;
            wild_q       <= '0;
            res_found_q  <= '0;
            res_status_q <= ST_OK;
            unique case (in_cmd)
              CMD_LOOKUP: state_q <= FSM_SCAN;
              CMD_REGISTER, CMD_UNREGISTER: begin
                if (in_h == '0) begin
                  res_status_q <= ST_ZERO_HANDLE;
                  state_q      <= FSM_DONE;
                end else begin
                  state_q <= FSM_SCAN;
                end
              end
              default: state_q <= FSM_DONE;
            endcase
          end
        end
        FSM_SCAN: begin
          // read slot idx while comparing the slot read in the previous cycle
          if (issue_vld) begin
            idx_q <= idx_q + 1'b1;
          end
          cmp_vld_q <= issue_vld;
          cmp_idx_q <= idx_q[IDX_W-1:0];
          if (cmp_vld_q) begin
            unique case (cmd_q)
              CMD_LOOKUP: begin
                if (cmp.exact) begin
                  res_found_q <= rd_entry.handle;
                  state_q     <= FSM_DONE;
                end else if (cmp.wild) begin
                  wild_q <= rd_entry.handle;
                end
              end
              CMD_REGISTER: begin
                if (cmp.free) begin
                  vld_q[cmp_idx_q] <= 1'b1;
                  state_q          <= FSM_DONE;
                end
              end
              CMD_UNREGISTER: begin
                if (cmp.hold) begin
                  vld_q[cmp_idx_q] <= 1'b0;
                  state_q          <= FSM_DONE;
                end
              end
              default: state_q <= FSM_DONE;
            endcase
          end else if (!issue_vld) begin
            // scan ran past the last slot without a hit
            unique case (cmd_q)
              CMD_LOOKUP:     res_found_q  <= wild_q;
              CMD_REGISTER:   res_status_q <= ST_FULL;
              CMD_UNREGISTER: res_status_q <= ST_NOT_FOUND;
              default:        res_status_q <= ST_OK;
            endcase
            state_q <= FSM_DONE;
          end
        end
        FSM_DONE: begin
          if (!m_tvalid_q || m_tready_i) begin
            m_tvalid_q <= 1'b1;
            m_data_q   <= {(OUT_W - OUT_USED_W)'(0), res_status_q, HFIELD_W'(res_found_q)};
            state_q    <= FSM_IDLE;
          end
        end
        default: state_q <= FSM_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ===== rtl/cdt_ram.sv =====
module cdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cdt_slot_cmp.sv =====
module cdt_slot_cmp import cdt_pkg::*; (
  input  entry_t  entry_i,
  input  logic    valid_i,
  input  port_t   local_port_i,
  input  port_t   remote_port_i,
  input  handle_t handle_i,
  output cmp_t    cmp_o
);

  logic lp_eq;

  assign lp_eq = valid_i && (entry_i.local_port == local_port_i);

  always_comb begin
    cmp_o.exact = lp_eq && (entry_i.remote_port == remote_port_i);
    cmp_o.wild  = lp_eq && (entry_i.remote_port == ANY_REMOTE);
    cmp_o.free  = !valid_i;
    cmp_o.hold  = valid_i && (entry_i.handle == handle_i);
  end

endmodule

// ===== rtl/cdt_checker.sv =====
module cdt_checker import cdt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_tvalid_i,
  input logic             s_tready_o,
  input logic             m_tvalid_o,
  input logic             m_tready_i,
  input logic [OUT_W-1:0] m_tdata_o
);

  // one item in flight: ready drops right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input taken while an item is in flight");

  // a new result only shows up after the block has been busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(!s_tready_o))
    else $error("result without work in progress");

  // an error status never carries a handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((m_tdata_o[HFIELD_W-1:0] == '0) ||
                    (m_tdata_o[HFIELD_W +: STATUS_W] == ST_OK)))
    else $error("handle reported with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled result changed");

endmodule

bind connection_demux_table_unit cdt_checker u_cdt_checker (.*);
